/* hdl/rlfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlfe_pkg;

    // counter width of the fade
    localparam int STEP_BITS = 10;

    // colour channels handled side by side
    localparam int NUM_LANES = 3;

    // widths inside the per-channel interpolator
    localparam int PROD_W    = 8 + STEP_BITS;          // diff * step
    localparam int NUM_W     = PROD_W + 2;             // 2 * prod + total
    localparam int DEN_W     = STEP_BITS + 1;          // 2 * total
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef logic [7:0]           colour_t;
    typedef colour_t [NUM_LANES-1:0] rgb_t;
    typedef logic [STEP_BITS-1:0] step_t;

    // action codes
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_SET   = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    // control from the sequencer to every lane
    typedef struct packed {
        logic  start;
        step_t step;
        step_t total;
    } lane_ctrl_t;

    // what one lane hands back
    typedef struct packed {
        logic    valid;
        colour_t value;
    } lane_stat_t;

endpackage

`default_nettype wire

/* hdl/rlfe_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlfe_lane
    import rlfe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire lane_ctrl_t ctrl,
    input  wire colour_t    from_val,
    input  wire colour_t    to_val,
    output lane_stat_t      stat
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } lane_state_t;

    lane_state_t            state_reg, state_next;
    logic                   valid_reg, valid_next;
    colour_t                value_reg, value_next;
    logic                   neg_reg, neg_next;
    colour_t                diff_reg, diff_next;
    colour_t                from_reg, from_next;
    step_t                  step_reg, step_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [NUM_W-1:0]       quot_reg, quot_next;
    logic [DEN_W-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    logic [PROD_W-1:0]      prod;
    logic [DEN_W:0]         rem_shift;
    logic                   qbit;
    logic [NUM_W-1:0]       quot_fin;
    logic [NUM_W:0]         from_wide;
    logic [NUM_W:0]         q_wide;
    logic [NUM_W:0]         sum_wide;

    // channel difference times step
    always_comb begin
        prod = PROD_W'(diff_reg) * PROD_W'(step_reg);
    end

    // one restoring division step
    always_comb begin
        rem_shift = {rem_reg, quot_reg[NUM_W-1]};
        qbit      = (rem_shift >= {1'b0, den_reg});
    end

    // final quotient and the widened operands of the channel value
    always_comb begin
        quot_fin  = {quot_reg[NUM_W-2:0], qbit};
        from_wide = {{(NUM_W+1-8){1'b0}}, from_reg};
        q_wide    = {1'b0, quot_fin};
        sum_wide  = from_wide + q_wide;
    end

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        diff_next  = diff_reg;
        from_next  = from_reg;
        step_next  = step_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    valid_next = 1'b0;
                    // zero step count lands on the target at once
                    if (ctrl.total == '0) begin
                        value_next = to_val;
                        valid_next = 1'b1;
                    end else begin
                        neg_next   = (to_val < from_val);
                        diff_next  = (to_val < from_val) ? (from_val - to_val)
                                                         : (to_val - from_val);
                        from_next  = from_val;
                        step_next  = ctrl.step;
                        den_next   = {ctrl.total, 1'b0};
                        state_next = L_MUL;
                    end
                end
            end
            L_MUL: begin
                state_next = L_DIV;
                cnt_next   = DIV_CNT_W'(NUM_W - 1);
                rem_next   = '0;
                // dividend 2 * prod + total, the added total gives the rounding
                quot_next  = NUM_W'({prod, 1'b0}) + NUM_W'(den_reg[DEN_W-1:1]);
            end
            L_DIV: begin
                rem_next  = qbit ? DEN_W'(rem_shift - {1'b0, den_reg})
                                 : rem_shift[DEN_W-1:0];
                quot_next = quot_fin;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (neg_reg) begin
                        value_next = (q_wide > from_wide) ? 8'd0
                                                          : 8'(from_wide - q_wide);
                    end else begin
                        value_next = (sum_wide > (NUM_W+1)'(255)) ? 8'd255
                                                                  : sum_wide[7:0];
                    end
                    valid_next = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        neg_reg   <= neg_next;
        diff_reg  <= diff_next;
        from_reg  <= from_next;
        step_reg  <= step_next;
        den_reg   <= den_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    assign stat.valid = valid_reg;
    assign stat.value = value_reg;

endmodule

`default_nettype wire

/* hdl/rgb_linear_fade_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-channel RGB fader on a stream interface. Every input word yields exactly one output
// word with the colour after the word and the done and running flags. Start, set colour,
// stop and a tick while the fade is stopped are answered in the cycle after acceptance.
// A tick during a running fade starts three interpolator lanes, one per channel, each doing
// a multiply followed by a restoring divider that retires one quotient bit per cycle; the
// output word is registered once every lane has its value.
// A new input word is taken while the previous output word is being handed off.

module rgb_linear_fade_engine
    import rlfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // red_in, green_in, blue_in, fade_length, zero pad
    input  wire logic [1:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // red_out, green_out, blue_out, fade_done,
                                        // fade_running, zero pad
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } seq_state_t;

    seq_state_t   state_reg, state_next;
    rgb_t         current_reg, current_next;
    rgb_t         start_reg, start_next;
    rgb_t         target_reg, target_next;
    step_t        count_reg, count_next;
    step_t        total_reg, total_next;
    logic         running_reg, running_next;
    logic         m_valid_reg, m_valid_next;
    logic [31:0]  m_data_reg, m_data_next;

    lane_ctrl_t   lane_ctrl;
    lane_stat_t   lane_stat [NUM_LANES];
    logic         lanes_valid;
    rgb_t         in_rgb;
    action_t      in_action;
    logic         accept;
    logic         load_out;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign in_rgb    = {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
    assign in_action = action_t'(s_tuser);

    // one interpolator per colour channel
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rlfe_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .from_val (start_reg[i]),
            .to_val   (target_reg[i]),
            .stat     (lane_stat[i])
        );
    end

    // merge the lane results
    always_comb begin
        lanes_valid = 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
            lanes_valid = lanes_valid & lane_stat[i].valid;
        end
    end

    // sequencer and fade state
    always_comb begin
        state_next      = state_reg;
        current_next    = current_reg;
        start_next      = start_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        running_next    = running_reg;
        load_out        = 1'b0;
        lane_ctrl.start = 1'b0;
        lane_ctrl.step  = count_reg;
        lane_ctrl.total = total_reg;
        if (accept) begin
            unique case (in_action)
                ACT_START: begin
                    target_next  = in_rgb;
                    start_next   = current_reg;
                    total_next   = STEP_BITS'(s_tdata[33:24]);
                    count_next   = '0;
                    running_next = 1'b1;
                    load_out     = 1'b1;
                end
                ACT_TICK: begin
                    if (running_reg) begin
                        lane_ctrl.start = 1'b1;
                        state_next      = ST_BUSY;
                    end else begin
                        load_out = 1'b1;
                    end
                end
                ACT_SET: begin
                    current_next = in_rgb;
                    load_out     = 1'b1;
                end
                ACT_STOP: begin
                    running_next = 1'b0;
                    load_out     = 1'b1;
                end
                default: begin
                    load_out = 1'b1;
                end
            endcase
        end
        // tick completes once every lane has its value
        if (state_reg == ST_BUSY && lanes_valid) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                current_next[i] = lane_stat[i].value;
            end
            if (count_reg < total_reg) begin
                count_next = count_reg + 1'b1;
            end else begin
                running_next = 1'b0;
                start_next   = target_reg;
            end
            state_next = ST_IDLE;
            load_out   = 1'b1;
        end
    end

    // output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, running_next, (count_next == total_next),
                            current_next[2], current_next[1], current_next[0]};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            current_reg <= '0;
            start_reg   <= '0;
            target_reg  <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            current_reg <= current_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
